/* rtl/cbeb_pkg.sv */
`default_nettype none

package cbeb_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_STEPS_DEF = 20;
  localparam int NCELL         = 3;
  localparam int NTERM         = 3;
  localparam int VAL_W_MIN     = 21;

  localparam int CX_W   = 17;
  localparam int CY_W   = 19;
  localparam int TOL_W  = 16;
  localparam int TIME_W = 18;
  localparam int PROG_W = 19;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 19;

  localparam logic [PROG_W-1:0] PROG_MIN = 19'h60000;
  localparam logic [PROG_W-1:0] PROG_MAX = 19'h30000;

  localparam logic [CX_W-1:0]  CTRL1_X_RST   = 17'd16384;
  localparam logic [CY_W-1:0]  CTRL1_Y_RST   = 19'd6554;
  localparam logic [CX_W-1:0]  CTRL2_X_RST   = 17'd16384;
  localparam logic [CY_W-1:0]  CTRL2_Y_RST   = 19'd65536;
  localparam logic [TOL_W-1:0] TOLERANCE_RST = 16'd16;

  typedef enum logic [IDX_W-1:0] {
    REG_CTRL1_X   = 3'd0,
    REG_CTRL1_Y   = 3'd1,
    REG_CTRL2_X   = 3'd2,
    REG_CTRL2_Y   = 3'd3,
    REG_TOLERANCE = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    TERM_C1   = 2'd0,
    TERM_C2   = 2'd1,
    TERM_CUBE = 2'd2
  } term_t;

  typedef struct packed {
    logic  vld;
    term_t tag;
  } cell_ctl_t;

  // Each term is a value multiplied in turn by three factors, each either (1-m) or m.
  function automatic logic uses_om(term_t tag, int unsigned k);
    logic r;
    case (tag)
      TERM_C1: r = (k < 2);
      TERM_C2: r = (k == 0);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/cubic_bezier_easing_bisect_top.sv */
// Cubic-bezier easing evaluator with bisection on the curve parameter.
// Configuration: cfg_we, cfg_index and cfg_data write one register per clock;
// write only while busy is low and no item is in flight.
// Input: an item is accepted at a rising edge where start is high and busy low.
// Output: out_strobe is high for exactly one cycle with out_progress,
// out_out_of_range and out_converged; the receiver cannot stall the block.
// Each polynomial evaluation is one pass of three terms through a row of three
// multiply cells. Bisection on x stops at the pass where the tolerance is met,
// or after MAX_STEPS passes; one further pass then evaluates y for the answer.
// An out-of-range time is answered in the next cycle.
// One item is worked on at a time; busy falls in the cycle its result is shown,
// and a new item may be accepted in that cycle.
// Reset restores the register defaults, empties the cell row and returns to idle.
`default_nettype none

module cubic_bezier_easing_bisect_top #(
  parameter int FRAC_BITS = cbeb_pkg::FRAC_BITS_DEF,
  parameter int MAX_STEPS = cbeb_pkg::MAX_STEPS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    start,
  output logic                                   busy,
  input  wire logic signed [cbeb_pkg::TIME_W-1:0] in_time_in,
  output logic                                   out_strobe,
  output logic signed [cbeb_pkg::PROG_W-1:0]     out_progress,
  output logic                                   out_out_of_range,
  output logic                                   out_converged,
  input  wire                                    cfg_we,
  input  wire logic [cbeb_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [cbeb_pkg::CFG_W-1:0]        cfg_data
);

  localparam int VAL_W  = (FRAC_BITS + 5 > cbeb_pkg::VAL_W_MIN) ? FRAC_BITS + 5
                                                                 : cbeb_pkg::VAL_W_MIN;
  localparam int SUM_W  = VAL_W + 2;
  localparam int CMP_W  = VAL_W + 3;
  localparam int POS_W  = FRAC_BITS + 1;
  localparam int STEP_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CX_W   = cbeb_pkg::CX_W;
  localparam int CY_W   = cbeb_pkg::CY_W;
  localparam int TOL_W  = cbeb_pkg::TOL_W;
  localparam int TIME_W = cbeb_pkg::TIME_W;
  localparam int PROG_W = cbeb_pkg::PROG_W;
  localparam int NCELL  = cbeb_pkg::NCELL;

  localparam logic [POS_W-1:0]        ONE_POS  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [POS_W-1:0]        HALF_POS = ONE_POS >> 1;
  localparam logic signed [CMP_W-1:0] ONE_CMP  = $signed({{(CMP_W-POS_W){1'b0}}, ONE_POS});
  localparam logic signed [VAL_W-1:0] ONE_VAL  = $signed({{(VAL_W-POS_W){1'b0}}, ONE_POS});
  localparam logic [STEP_W-1:0]       STEP_LAST = STEP_W'(MAX_STEPS - 1);
  localparam logic [1:0]              RCV_LAST  = 2'(cbeb_pkg::NTERM - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EVAL  = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_CHECK = 4'b1000
  } state_t;

  function automatic logic [PROG_W-1:0] sat(input logic signed [CMP_W-1:0] v);
    logic signed [CMP_W-1:0] lo;
    logic signed [CMP_W-1:0] hi;
    logic [PROG_W-1:0]       r;
    lo = $signed({{(CMP_W-PROG_W){cbeb_pkg::PROG_MIN[PROG_W-1]}}, cbeb_pkg::PROG_MIN});
    hi = $signed({{(CMP_W-PROG_W){cbeb_pkg::PROG_MAX[PROG_W-1]}}, cbeb_pkg::PROG_MAX});
    if (v < lo) begin
      r = cbeb_pkg::PROG_MIN;
    end else if (v > hi) begin
      r = cbeb_pkg::PROG_MAX;
    end else begin
      r = v[PROG_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic [CX_W-1:0]  c1x_r, c2x_r;
  logic [CY_W-1:0]  c1y_r, c2y_r;
  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1x_r <= cbeb_pkg::CTRL1_X_RST;
      c1y_r <= cbeb_pkg::CTRL1_Y_RST;
      c2x_r <= cbeb_pkg::CTRL2_X_RST;
      c2y_r <= cbeb_pkg::CTRL2_Y_RST;
      tol_r <= cbeb_pkg::TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cbeb_pkg::reg_idx_t'(cfg_index))
        cbeb_pkg::REG_CTRL1_X:   c1x_r <= cfg_data[CX_W-1:0];
        cbeb_pkg::REG_CTRL1_Y:   c1y_r <= cfg_data[CY_W-1:0];
        cbeb_pkg::REG_CTRL2_X:   c2x_r <= cfg_data[CX_W-1:0];
        cbeb_pkg::REG_CTRL2_Y:   c2y_r <= cfg_data[CY_W-1:0];
        cbeb_pkg::REG_TOLERANCE: tol_r <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Control and datapath registers.
  state_t                     state_r, state_nxt;
  logic [TIME_W-1:0]          time_r, time_nxt;
  logic [POS_W-1:0]           start_r, start_nxt;
  logic [POS_W-1:0]           end_r, end_nxt;
  logic [POS_W-1:0]           mid_r, mid_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [1:0]                 iss_r, iss_nxt;
  logic [1:0]                 rcv_r, rcv_nxt;
  logic                       phase_y_r, phase_y_nxt;
  logic                       conv_r, conv_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic                       strobe_r, strobe_nxt;
  logic [PROG_W-1:0]          prog_r, prog_nxt;
  logic                       oor_r, oor_nxt;
  logic                       oconv_r, oconv_nxt;

  // Cell row.
  cbeb_pkg::cell_ctl_t        ctl [NCELL+1];
  logic signed [VAL_W-1:0]    val [NCELL+1];
  logic [POS_W-1:0]           fac [NCELL];
  logic [POS_W-1:0]           om;
  logic signed [VAL_W-1:0]    c1v, c2v, c1_3, c2_3;

  assign om = ONE_POS - mid_r;

  always_comb begin
    c1v = phase_y_r ? $signed({{(VAL_W-CY_W){c1y_r[CY_W-1]}}, c1y_r})
                    : $signed({{(VAL_W-CX_W){1'b0}}, c1x_r});
    c2v = phase_y_r ? $signed({{(VAL_W-CY_W){c2y_r[CY_W-1]}}, c2y_r})
                    : $signed({{(VAL_W-CX_W){1'b0}}, c2x_r});
    c1_3 = (c1v <<< 1) + c1v;
    c2_3 = (c2v <<< 1) + c2v;
    ctl[0].vld = (state_r == ST_EVAL);
    ctl[0].tag = cbeb_pkg::term_t'(iss_r);
    case (ctl[0].tag)
      cbeb_pkg::TERM_C1: val[0] = c1_3;
      cbeb_pkg::TERM_C2: val[0] = c2_3;
      default:           val[0] = ONE_VAL;
    endcase
  end

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    assign fac[k] = cbeb_pkg::uses_om(ctl[k].tag, k) ? om : mid_r;
    cbeb_cell #(
      .FRAC_BITS (FRAC_BITS),
      .VAL_W     (VAL_W)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl[k]),
      .val_i (val[k]),
      .fac_i (fac[k]),
      .ctl_o (ctl[k+1]),
      .val_o (val[k+1])
    );
  end

  // Bisection decision.
  logic signed [CMP_W-1:0] tin, tt, est, diff, absd;
  logic                    hit, below, in_oor;
  logic [POS_W-1:0]        nstart, nend;
  logic [POS_W:0]          msum;

  always_comb begin
    tin    = $signed({{(CMP_W-TIME_W){in_time_in[TIME_W-1]}}, in_time_in});
    in_oor = (tin < 0) || (tin > ONE_CMP);
    tt     = $signed({{(CMP_W-TIME_W){time_r[TIME_W-1]}}, time_r});
    est    = $signed({sum_r[SUM_W-1], sum_r});
    diff   = tt - est;
    absd   = diff[CMP_W-1] ? -diff : diff;
    hit    = absd <= $signed({{(CMP_W-TOL_W){1'b0}}, tol_r});
    below  = est < tt;
    nstart = below ? mid_r : start_r;
    nend   = below ? end_r : mid_r;
    msum   = {1'b0, nstart} + {1'b0, nend};
  end

  always_comb begin
    state_nxt   = state_r;
    time_nxt    = time_r;
    start_nxt   = start_r;
    end_nxt     = end_r;
    mid_nxt     = mid_r;
    step_nxt    = step_r;
    iss_nxt     = iss_r;
    rcv_nxt     = rcv_r;
    phase_y_nxt = phase_y_r;
    conv_nxt    = conv_r;
    sum_nxt     = sum_r;
    strobe_nxt  = 1'b0;
    prog_nxt    = prog_r;
    oor_nxt     = oor_r;
    oconv_nxt   = oconv_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_oor) begin
            strobe_nxt = 1'b1;
            prog_nxt   = sat(ONE_CMP);
            oor_nxt    = 1'b1;
            oconv_nxt  = 1'b0;
          end else begin
            time_nxt    = in_time_in;
            start_nxt   = '0;
            end_nxt     = ONE_POS;
            mid_nxt     = HALF_POS;
            step_nxt    = '0;
            iss_nxt     = '0;
            rcv_nxt     = '0;
            phase_y_nxt = 1'b0;
            conv_nxt    = 1'b0;
            state_nxt   = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        sum_nxt = '0;
        if (iss_r == RCV_LAST) begin
          iss_nxt   = '0;
          state_nxt = ST_WAIT;
        end else begin
          iss_nxt = iss_r + 2'd1;
        end
      end
      ST_WAIT: begin
        if (ctl[NCELL].vld) begin
          sum_nxt = sum_r + $signed({{2{val[NCELL][VAL_W-1]}}, val[NCELL]});
          if (rcv_r == RCV_LAST) begin
            rcv_nxt   = '0;
            state_nxt = ST_CHECK;
          end else begin
            rcv_nxt = rcv_r + 2'd1;
          end
        end
      end
      ST_CHECK: begin
        if (phase_y_r) begin
          strobe_nxt = 1'b1;
          prog_nxt   = sat(est);
          oor_nxt    = 1'b0;
          oconv_nxt  = conv_r;
          state_nxt  = ST_IDLE;
        end else if (hit) begin
          conv_nxt    = 1'b1;
          phase_y_nxt = 1'b1;
          state_nxt   = ST_EVAL;
        end else if (step_r == STEP_LAST) begin
          phase_y_nxt = 1'b1;
          state_nxt   = ST_EVAL;
        end else begin
          step_nxt  = step_r + 1'b1;
          start_nxt = nstart;
          end_nxt   = nend;
          mid_nxt   = msum[POS_W:1];
          state_nxt = ST_EVAL;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      step_r    <= '0;
      iss_r     <= '0;
      rcv_r     <= '0;
      phase_y_r <= 1'b0;
      conv_r    <= 1'b0;
      strobe_r  <= 1'b0;
      mid_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      iss_r     <= iss_nxt;
      rcv_r     <= rcv_nxt;
      phase_y_r <= phase_y_nxt;
      conv_r    <= conv_nxt;
      strobe_r  <= strobe_nxt;
      mid_r     <= mid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r  <= time_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    sum_r   <= sum_nxt;
    prog_r  <= prog_nxt;
    oor_r   <= oor_nxt;
    oconv_r <= oconv_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = strobe_r;
  assign out_progress     = $signed(prog_r);
  assign out_out_of_range = oor_r;
  assign out_converged    = oconv_r;

  // A finished item always shows its result in the cycle busy drops.
  a_result_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_strobe)
    else $error("busy fell without a result");

  // Terms leave the cell row only while the block waits for them.
  a_row_out_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ctl[NCELL].vld |-> (state_r == ST_WAIT))
    else $error("term left the cell row outside the wait state");

  // A result cannot be both converged and out of range.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_converged && out_out_of_range))
    else $error("converged and out of range together");

  // The midpoint stays inside the unit interval.
  a_mid_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (mid_r <= ONE_POS))
    else $error("midpoint outside the unit interval");

endmodule

`default_nettype wire

/* rtl/cbeb_cell.sv */
`default_nettype none

module cbeb_cell #(
  parameter int FRAC_BITS = cbeb_pkg::FRAC_BITS_DEF,
  parameter int VAL_W     = cbeb_pkg::VAL_W_MIN
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire cbeb_pkg::cell_ctl_t        ctl_i,
  input  wire logic signed [VAL_W-1:0]    val_i,
  input  wire logic [FRAC_BITS:0]         fac_i,
  output cbeb_pkg::cell_ctl_t             ctl_o,
  output logic signed [VAL_W-1:0]         val_o
);

  cbeb_pkg::cell_ctl_t               ctl_r;
  logic signed [VAL_W-1:0]           val_r;
  logic signed [VAL_W-1:0]           val_nxt;
  logic signed [VAL_W+FRAC_BITS+1:0] prod;

  assign prod    = val_i * $signed({1'b0, fac_i});
  assign val_nxt = prod[FRAC_BITS+VAL_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign ctl_o = ctl_r;
  assign val_o = val_r;

endmodule

`default_nettype wire

/* verif/cubic_bezier_easing_bisect_top_tb.sv */
`timescale 1ns / 1ps

module cubic_bezier_easing_bisect_top_tb;

  localparam int WATCHDOG = 20000;
  localparam logic [cbeb_pkg::IDX_W-1:0] IDX_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [cbeb_pkg::PROG_W-1:0] progress;
    logic                               out_of_range;
    logic                               converged;
  } easing_t;

  typedef struct {
    logic signed [cbeb_pkg::TIME_W-1:0] t;
    bit                                 known;
    easing_t                            res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [cbeb_pkg::TIME_W-1:0] in_time_in = '0;
  logic out_strobe;
  logic signed [cbeb_pkg::PROG_W-1:0] out_progress;
  logic out_out_of_range;
  logic out_converged;
  logic cfg_we = 1'b0;
  logic [cbeb_pkg::IDX_W-1:0] cfg_index = '0;
  logic [cbeb_pkg::CFG_W-1:0] cfg_data = '0;

  longint c1x, c1y, c2x, c2y, tol;
  easing_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  cubic_bezier_easing_bisect_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_time_in(in_time_in),
    .out_strobe(out_strobe), .out_progress(out_progress),
    .out_out_of_range(out_out_of_range), .out_converged(out_converged),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint fix_down(longint v);
    return v >>> 16;
  endfunction

  function automatic longint curve(longint a, longint b, longint m);
    longint om;
    om = 65536 - m;
    return fix_down(fix_down(fix_down(3 * a * om) * om) * m)
         + fix_down(fix_down(fix_down(3 * b * om) * m) * m)
         + fix_down(fix_down(m * m) * m);
  endfunction

  function automatic easing_t ease(logic signed [cbeb_pkg::TIME_W-1:0] t_in);
    easing_t r;
    longint t, lo, hi, mid, est, d, p;
    t = t_in;
    r.converged = 1'b0;
    r.out_of_range = 1'b0;
    if (t < 0 || t > 65536) begin
      p = 65536;
      r.out_of_range = 1'b1;
    end else begin
      lo = 0;
      hi = 65536;
      mid = 0;
      for (int i = 0; i < 20; i++) begin
        mid = (lo + hi) >>> 1;
        est = curve(c1x, c2x, mid);
        d = t - est;
        if (d < 0) d = -d;
        if (d <= tol) begin
          r.converged = 1'b1;
          break;
        end
        if (est < t) lo = mid;
        else hi = mid;
      end
      p = curve(c1y, c2y, mid);
    end
    if (p < -131072) p = -131072;
    if (p > 196608) p = 196608;
    r.progress = p[cbeb_pkg::PROG_W-1:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      easing_t e;
      if (pending_q.size() == 0) begin
        report("unexpected item", out_progress, 0);
      end else begin
        e = pending_q.pop_front();
        if (out_progress !== e.progress) report("progress", out_progress, e.progress);
        if (out_out_of_range !== e.out_of_range)
          report("out_of_range", out_out_of_range, e.out_of_range);
        if (out_converged !== e.converged) report("converged", out_converged, e.converged);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(logic [cbeb_pkg::IDX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[cbeb_pkg::CFG_W-1:0];
    @(posedge clk);
    case (cbeb_pkg::reg_idx_t'(idx))
      cbeb_pkg::REG_CTRL1_X: c1x = val & 17'h1FFFF;
      cbeb_pkg::REG_CTRL1_Y: c1y = longint'($signed(val[cbeb_pkg::CY_W-1:0]));
      cbeb_pkg::REG_CTRL2_X: c2x = val & 17'h1FFFF;
      cbeb_pkg::REG_CTRL2_Y: c2y = longint'($signed(val[cbeb_pkg::CY_W-1:0]));
      cbeb_pkg::REG_TOLERANCE: tol = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic cfg_done;
    cfg_we <= 1'b0;
  endtask

  task automatic set_curve(longint ax, longint ay, longint bx, longint by, longint tl);
    write_reg(cbeb_pkg::REG_CTRL1_X, ax);
    write_reg(cbeb_pkg::REG_CTRL1_Y, ay);
    write_reg(cbeb_pkg::REG_CTRL2_X, bx);
    write_reg(cbeb_pkg::REG_CTRL2_Y, by);
    write_reg(cbeb_pkg::REG_TOLERANCE, tl);
  endtask

  task automatic send_time(logic signed [cbeb_pkg::TIME_W-1:0] t, easing_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    in_time_in <= t;
    do @(posedge clk); while (busy);
    pending_q.push_back(want);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [cbeb_pkg::TIME_W-1:0] rand_time;
    int k;
    int v;
    k = $urandom_range(0, 19);
    if (k == 0) v = $urandom;
    else if (k == 1) v = -int'($urandom_range(1, 131072));
    else if (k == 2) v = $urandom_range(0, 3);
    else if (k == 3) v = 65536 - int'($urandom_range(0, 3));
    else v = $urandom_range(0, 65536);
    return v[cbeb_pkg::TIME_W-1:0];
  endfunction

  row_t rows[$];

  initial begin
    easing_t oor;
    oor.progress = 19'sd65536;
    oor.out_of_range = 1'b1;
    oor.converged = 1'b0;
    c1x = cbeb_pkg::CTRL1_X_RST;
    c1y = longint'($signed(cbeb_pkg::CTRL1_Y_RST));
    c2x = cbeb_pkg::CTRL2_X_RST;
    c2y = longint'($signed(cbeb_pkg::CTRL2_Y_RST));
    tol = cbeb_pkg::TOLERANCE_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{18'sd0, 1'b0, oor}, '{18'sd65536, 1'b0, oor}, '{18'sd32768, 1'b0, oor},
      '{18'sd1, 1'b0, oor}, '{18'sd65535, 1'b0, oor}, '{18'sd65537, 1'b1, oor},
      '{18'sd131071, 1'b1, oor}, '{-18'sd1, 1'b1, oor}, '{-18'sd131072, 1'b1, oor},
      '{18'sd21845, 1'b0, oor}, '{18'sd43690, 1'b0, oor}, '{18'sd10000, 1'b0, oor}
    };
    foreach (rows[i]) send_time(rows[i].t, rows[i].known ? rows[i].res : ease(rows[i].t));
    drain();

    set_curve(0, -131072, 65536, 196608, 0);
    cfg_done();
    foreach (rows[i]) send_time(rows[i].t, ease(rows[i].t));
    drain();
    set_curve(131071, 262143, 131071, 131071, 65535);
    write_reg(IDX_UNUSED, 5);
    cfg_done();
    for (int i = 0; i < 6; i++) send_time(rows[i].t, ease(rows[i].t));
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph % 3 == 0) set_curve($urandom_range(0, 131071), $urandom, $urandom_range(0, 131071),
                                 $urandom, $urandom_range(0, 65535));
      else set_curve($urandom_range(0, 65536), $urandom_range(0, 327680) - 131072,
                     $urandom_range(0, 65536), $urandom_range(0, 327680) - 131072,
                     $urandom_range(0, 64));
      cfg_done();
      if (ph == 12) quiet = 1'b1;
      for (int i = 0; i < 100; i++) begin
        logic signed [cbeb_pkg::TIME_W-1:0] t;
        t = rand_time();
        send_time(t, ease(t));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
